// ===== src/tssr_pkg.sv =====
// ----------------------------------------------------------------------------
// tssr_pkg
// Shared types and constants of the tile and sprite scanline renderer.
// ----------------------------------------------------------------------------
`default_nettype none
package tssr_pkg;

  localparam int unsigned VideoBytes    = 8192;
  localparam int unsigned SpriteCount   = 40;
  localparam int unsigned LineWidth     = 160;
  localparam int unsigned LinesPerFrame = 154;
  localparam int unsigned SpriteBytes   = 160;
  localparam int unsigned VisibleLines  = 144;
  localparam int unsigned VblankLine    = 145;
  localparam int unsigned Groups        = (LineWidth + 7) / 8;

  localparam int unsigned VaW = $clog2(VideoBytes);
  localparam int unsigned SaW = $clog2(SpriteBytes);
  localparam int unsigned XW  = $clog2(LineWidth);
  localparam int unsigned GW  = 5;

  localparam logic [1:0] OpVram   = 2'd0;
  localparam logic [1:0] OpSprite = 2'd1;
  localparam logic [1:0] OpRender = 2'd2;

  localparam logic [2:0] RegLcdc = 3'd0;
  localparam logic [2:0] RegScy  = 3'd1;
  localparam logic [2:0] RegScx  = 3'd2;
  localparam logic [2:0] RegWy   = 3'd3;
  localparam logic [2:0] RegWx   = 3'd4;
  localparam logic [2:0] RegBgp  = 3'd5;
  localparam logic [2:0] RegObp0 = 3'd6;
  localparam logic [2:0] RegObp1 = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [12:0] mem_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  line_number;
    logic [4:0]  pixel_group;
    logic [15:0] pixel_shades;
    logic [7:0]  written_mask;
    logic        last_group;
    logic        vblank_raise;
  } out_item_t;

  typedef struct packed {
    logic [7:0] lcdc;
    logic [7:0] scy;
    logic [7:0] scx;
    logic [7:0] wy;
    logic [7:0] wx;
    logic [7:0] bgp;
    logic [7:0] obp0;
    logic [7:0] obp1;
  } regs_t;

  // line buffer access from the engine
  typedef struct packed {
    logic          we;
    logic [XW-1:0] waddr;
    logic [2:0]    wdata;
    logic [XW-1:0] raddr;
  } lb_req_t;

  function automatic logic [1:0] pal_map(logic [7:0] pal, logic [1:0] c);
    pal_map = pal[2*c +: 2];
  endfunction

endpackage
`default_nettype wire

// ===== src/tssr_vram.sv =====
// ----------------------------------------------------------------------------
// tssr_vram
// Video memory: one write or one read port per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tssr_vram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [tssr_pkg::VaW-1:0] addr_i,
  input  wire logic [7:0]               wdata_i,
  output logic      [7:0]               rdata_o
);
  logic [7:0] mem [tssr_pkg::VideoBytes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ===== src/tssr_oam.sv =====
// ----------------------------------------------------------------------------
// tssr_oam
// Sprite attribute memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tssr_oam (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [tssr_pkg::SaW-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic [tssr_pkg::SaW-1:0] raddr_i,
  output logic      [7:0]               rdata_o
);
  logic [7:0] mem [tssr_pkg::SpriteBytes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/tssr_linebuf.sv =====
// ----------------------------------------------------------------------------
// tssr_linebuf
// Line buffer of drawn bit and shade per pixel, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tssr_linebuf (
  input  wire logic              clk_i,
  input  wire tssr_pkg::lb_req_t req_i,
  output logic      [2:0]        rdata_o
);
  logic [2:0] mem [tssr_pkg::LineWidth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end
endmodule
`default_nettype wire

// ===== src/tile_sprite_scanline_renderer.sv =====
// ----------------------------------------------------------------------------
// tile_sprite_scanline_renderer
// Scanline renderer of tiles and sprites over video and sprite memories.
// ----------------------------------------------------------------------------
// Memory writes are accepted only while idle. A render walks the line buffer
// through a single-port video memory: a clear pass over all 160 pixels, a
// background pass that reads a map entry and two tile bytes for each pixel, a
// sprite pass that reads the four attribute bytes of each of the 40 sprites and
// fetches two tile bytes and draws eight pixels for each sprite on the line,
// and a readout in 20 beats of eight pixels; a held beat stalls the readout.
// The background pass needs a visible line and lcdc[0], the sprite pass a
// visible line and lcdc[1]. Input is held off for the whole render.
`default_nettype none
module tile_sprite_scanline_renderer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire tssr_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output tssr_pkg::out_item_t       out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);
  typedef enum logic [3:0] {
    StIdle, StClear, StBgA, StBgB, StBgC, StBgD,
    StSpA, StSpB, StSpC, StSpD, StSpPix,
    StOutRd, StOutAcc, StOutWait
  } state_e;

  localparam int unsigned XW = tssr_pkg::XW;
  localparam int unsigned SIW = $clog2(tssr_pkg::SpriteCount + 1);

  state_e              state_q;
  tssr_pkg::regs_t     regs_q;
  logic [7:0]          line_q;
  logic [XW:0]         x_q;
  logic [SIW-1:0]      spr_q;
  logic [1:0]          sub_q;
  logic [7:0]          num_q, lo_q, spy_q, spx_q, stile_q, sattr_q;
  logic [2:0]          k_q;
  logic [4:0]          grp_q;
  logic [15:0]         sh_q;
  logic [7:0]          mk_q;
  logic                out_valid_q;
  tssr_pkg::out_item_t out_q;

  logic [7:0] vram_rd, oam_rd;
  logic [2:0] lb_rd;
  logic       vram_we;
  logic [tssr_pkg::VaW-1:0] vram_addr;
  logic [tssr_pkg::SaW-1:0] oam_raddr;
  tssr_pkg::lb_req_t lb_req;

  logic in_acc, out_acc, cfg_wr;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // background geometry of pixel x_q
  logic       win_on, in_win;
  logic [7:0] win_left, xb, ypos, xpos, tnum;
  logic [tssr_pkg::VaW-1:0] map_base, map_addr, tile_base, row_addr;
  assign win_on   = regs_q.lcdc[5] && (regs_q.wy <= line_q);
  assign win_left = regs_q.wx - 8'd7;
  assign xb       = x_q[7:0];
  assign in_win   = win_on && (xb >= win_left);
  assign ypos     = in_win ? (line_q - regs_q.wy) : (regs_q.scy + line_q);
  assign xpos     = in_win ? (xb - win_left) : (xb + regs_q.scx);
  assign map_base = (in_win ? regs_q.lcdc[6] : regs_q.lcdc[3]) ? 13'h1C00 : 13'h1800;
  assign map_addr = map_base + {3'd0, ypos[7:3], xpos[7:3]};
  assign tnum     = (state_q == StBgB) ? vram_rd : num_q;
  assign tile_base = regs_q.lcdc[4] ? {1'b0, tnum, 4'd0}
                                    : (13'h0800 + {1'b0, (tnum ^ 8'h80), 4'd0});
  assign row_addr = tile_base + {9'd0, ypos[2:0], 1'b0};
  logic [2:0] bg_bit;
  logic [1:0] bg_c;
  assign bg_bit = 3'd7 - xpos[2:0];
  assign bg_c   = {vram_rd[bg_bit], lo_q[bg_bit]};

  // sprite geometry
  logic [7:0] height, top, left, srow_raw, srow, sx;
  logic [8:0] top_end;
  logic       hit;
  logic [tssr_pkg::VaW-1:0] spr_row_addr;
  logic [2:0] sp_bit;
  logic [1:0] sp_c;
  assign height  = regs_q.lcdc[2] ? 8'd16 : 8'd8;
  assign top     = spy_q - 8'd16;
  assign left    = spx_q - 8'd8;
  assign top_end = {1'b0, top} + {1'b0, height};
  assign hit     = ({1'b0, line_q} >= {1'b0, top}) && ({1'b0, line_q} < top_end);
  assign srow_raw = line_q - top;
  assign srow    = sattr_q[6] ? (height - 8'd1 - srow_raw) : srow_raw;
  assign spr_row_addr = {1'b0, stile_q, 4'd0} + {4'd0, srow, 1'b0};
  assign sp_bit  = sattr_q[5] ? k_q : (3'd7 - k_q);
  assign sp_c    = {num_q[sp_bit], lo_q[sp_bit]};
  assign sx      = left + {5'd0, k_q};

  always_comb begin
    vram_we   = 1'b0;
    vram_addr = map_addr;
    oam_raddr = tssr_pkg::SaW'({spr_q, sub_q});
    lb_req    = '0;
    lb_req.raddr = x_q[XW-1:0];
    case (state_q)
      StIdle: begin
        vram_we   = in_acc && (in_data_i.opcode == tssr_pkg::OpVram);
        vram_addr = in_data_i.mem_address;
      end
      StClear: begin
        lb_req.we    = 1'b1;
        lb_req.waddr = x_q[XW-1:0];
        lb_req.wdata = 3'd0;
      end
      StBgA: vram_addr = map_addr;
      StBgB: vram_addr = row_addr;
      StBgC: vram_addr = row_addr + 13'd1;
      StBgD: begin
        lb_req.we    = 1'b1;
        lb_req.waddr = x_q[XW-1:0];
        lb_req.wdata = {1'b1, tssr_pkg::pal_map(regs_q.bgp, bg_c)};
      end
      StSpD: vram_addr = spr_row_addr;
      StSpPix: begin
        vram_addr = spr_row_addr + 13'd1;
        lb_req.we    = (sp_c != 2'd0) && ({1'b0, sx} < 9'(tssr_pkg::LineWidth))
                       && (sub_q == 2'd1);
        lb_req.waddr = sx[XW-1:0];
        lb_req.wdata = {1'b1, tssr_pkg::pal_map(sattr_q[4] ? regs_q.obp1 : regs_q.obp0,
                                                 sp_c)};
      end
      default: ;
    endcase
  end

  tssr_vram u_vram (
    .clk_i(clk_i), .we_i(vram_we), .addr_i(vram_addr),
    .wdata_i(in_data_i.write_data), .rdata_o(vram_rd)
  );

  tssr_oam u_oam (
    .clk_i(clk_i),
    .we_i(in_acc && (in_data_i.opcode == tssr_pkg::OpSprite)
          && (in_data_i.mem_address < 13'(tssr_pkg::SpriteBytes))),
    .waddr_i(in_data_i.mem_address[tssr_pkg::SaW-1:0]),
    .wdata_i(in_data_i.write_data), .raddr_i(oam_raddr), .rdata_o(oam_rd)
  );

  tssr_linebuf u_lb (.clk_i(clk_i), .req_i(lb_req), .rdata_o(lb_rd));

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      tssr_pkg::RegLcdc: prdata[7:0] = regs_q.lcdc;
      tssr_pkg::RegScy:  prdata[7:0] = regs_q.scy;
      tssr_pkg::RegScx:  prdata[7:0] = regs_q.scx;
      tssr_pkg::RegWy:   prdata[7:0] = regs_q.wy;
      tssr_pkg::RegWx:   prdata[7:0] = regs_q.wx;
      tssr_pkg::RegBgp:  prdata[7:0] = regs_q.bgp;
      tssr_pkg::RegObp0: prdata[7:0] = regs_q.obp0;
      tssr_pkg::RegObp1: prdata[7:0] = regs_q.obp1;
      default: prdata = '0;
    endcase
  end

  logic last_pix, visible;
  assign last_pix = (x_q == (XW+1)'(tssr_pkg::LineWidth - 1));
  assign visible  = (line_q < 8'(tssr_pkg::VisibleLines));
  logic [7:0] next_line;
  assign next_line = (line_q == 8'(tssr_pkg::LinesPerFrame - 1)) ? 8'd0 : line_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      regs_q <= '0;
      line_q <= '0;
      x_q <= '0;
      spr_q <= '0;
      sub_q <= '0;
      k_q <= '0;
      grp_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          tssr_pkg::RegLcdc: regs_q.lcdc <= pwdata[7:0];
          tssr_pkg::RegScy:  regs_q.scy  <= pwdata[7:0];
          tssr_pkg::RegScx:  regs_q.scx  <= pwdata[7:0];
          tssr_pkg::RegWy:   regs_q.wy   <= pwdata[7:0];
          tssr_pkg::RegWx:   regs_q.wx   <= pwdata[7:0];
          tssr_pkg::RegBgp:  regs_q.bgp  <= pwdata[7:0];
          tssr_pkg::RegObp0: regs_q.obp0 <= pwdata[7:0];
          tssr_pkg::RegObp1: regs_q.obp1 <= pwdata[7:0];
          default: ;
        endcase
      end
      if (out_acc && (state_q != StOutWait)) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          x_q <= '0;
          if (in_acc && in_data_i.opcode == tssr_pkg::OpRender) state_q <= StClear;
        end
        StClear: begin
          x_q <= last_pix ? '0 : x_q + 1'b1;
          if (last_pix) begin
            spr_q <= '0;
            sub_q <= '0;
            if (visible && regs_q.lcdc[0]) state_q <= StBgA;
            else if (visible && regs_q.lcdc[1]) state_q <= StSpA;
            else state_q <= StOutRd;
          end
        end
        StBgA: state_q <= StBgB;
        StBgB: begin num_q <= vram_rd; state_q <= StBgC; end
        StBgC: begin lo_q <= vram_rd; state_q <= StBgD; end
        StBgD: begin
          x_q <= last_pix ? '0 : x_q + 1'b1;
          if (!last_pix) state_q <= StBgA;
          else if (regs_q.lcdc[1]) state_q <= StSpA;
          else state_q <= StOutRd;
        end
        StSpA: begin
          // table read issued for sub_q; data arrives next cycle
          state_q <= StSpB;
        end
        StSpB: begin
          case (sub_q)
            2'd0: spy_q <= oam_rd;
            2'd1: spx_q <= oam_rd;
            2'd2: stile_q <= oam_rd;
            default: sattr_q <= oam_rd;
          endcase
          sub_q <= sub_q + 2'd1;
          state_q <= (sub_q == 2'd3) ? StSpC : StSpA;
        end
        StSpC: begin
          k_q <= '0;
          sub_q <= '0;
          if (hit) state_q <= StSpD;
          else if (spr_q == SIW'(tssr_pkg::SpriteCount - 1)) state_q <= StOutRd;
          else begin spr_q <= spr_q + 1'b1; state_q <= StSpA; end
        end
        StSpD: state_q <= StSpPix;
        StSpPix: begin
          if (sub_q == 2'd0) begin
            lo_q <= vram_rd;
            sub_q <= 2'd2;
          end else if (sub_q == 2'd2) begin
            num_q <= vram_rd;
            sub_q <= 2'd1;
          end else begin
            k_q <= k_q + 3'd1;
            if (k_q == 3'd7) begin
              sub_q <= '0;
              x_q <= '0;
              if (spr_q == SIW'(tssr_pkg::SpriteCount - 1)) state_q <= StOutRd;
              else begin spr_q <= spr_q + 1'b1; state_q <= StSpA; end
            end
          end
        end
        StOutRd: state_q <= StOutAcc;
        StOutAcc: begin
          sh_q[2*x_q[2:0] +: 2] <= lb_rd[2] ? lb_rd[1:0] : 2'd0;
          mk_q[x_q[2:0]] <= lb_rd[2];
          if (x_q[2:0] == 3'd7) state_q <= StOutWait;
          else begin x_q <= x_q + 1'b1; state_q <= StOutRd; end
        end
        StOutWait: begin
          if (!out_valid_q || out_acc) begin
            out_valid_q <= 1'b1;
            out_q.line_number  <= line_q;
            out_q.pixel_group  <= grp_q;
            out_q.pixel_shades <= sh_q;
            out_q.written_mask <= mk_q;
            out_q.last_group   <= (grp_q == 5'(tssr_pkg::Groups - 1));
            out_q.vblank_raise <= (grp_q == 5'(tssr_pkg::Groups - 1))
                                  && (next_line == 8'(tssr_pkg::VblankLine));
            if (grp_q == 5'(tssr_pkg::Groups - 1)) begin
              grp_q <= '0;
              x_q <= '0;
              line_q <= next_line;
              state_q <= StIdle;
            end else begin
              grp_q <= grp_q + 5'd1;
              x_q <= x_q + 1'b1;
              state_q <= StOutRd;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle)) else $error("ready outside idle");
  ap_last_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.vblank_raise) |-> out_data_o.last_group)
    else $error("vblank without last group");
  ap_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q < 8'(tssr_pkg::LinesPerFrame)) else $error("line out of range");
  ap_grp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_q < 5'(tssr_pkg::Groups)) else $error("group out of range");
`endif
endmodule
`default_nettype wire
